[design/lapc_pkg.sv]
// Shared types, constants and helper functions for the layered alpha pixel compositor.
// No dependencies; every design file imports this package.
package lapc_pkg;

  // Field widths
  localparam int COORD_WIDTH     = 12;
  localparam int DIM_WIDTH       = 13;
  localparam int STRIDE_WIDTH    = 14;
  localparam int ARGB_WIDTH      = 32;
  localparam int INDEX_WIDTH     = 25;
  localparam int WORD_WIDTH      = 24;
  localparam int CFG_DATA_WIDTH  = 14;
  localparam int CFG_INDEX_WIDTH = 3;

  // Gradient parameter t is an 8-bit quotient, one bit per divider stage
  localparam int T_WIDTH    = 8;
  localparam int DIV_STAGES = T_WIDTH;
  // Each layer blend takes a multiply stage and a divide-by-255 stage
  localparam int BLEND_LAT  = 2;

  // Register reset values
  localparam logic [DIM_WIDTH-1:0]    WIDTH_RESET  = DIM_WIDTH'(1024);
  localparam logic [DIM_WIDTH-1:0]    HEIGHT_RESET = DIM_WIDTH'(768);
  localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = STRIDE_WIDTH'(1024);

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_LINE_STRIDE   = 3'd2,
    REG_PIXEL_ORDER   = 3'd3,
    REG_TOP_WINDOW    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [ARGB_WIDTH-1:0]  window_one_pixel;
    logic [ARGB_WIDTH-1:0]  window_two_pixel;
    logic [ARGB_WIDTH-1:0]  taskbar_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] pixel_index;
    logic [WORD_WIDTH-1:0]  pixel_word;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Background line geometry, in percent of the screen size; the line gap is in rows
  localparam int LINE_ROW_PCT = 52;
  localparam int LINE_GAP     = 38;
  localparam int LINE_A_L_PCT = 18;
  localparam int LINE_A_R_PCT = 90;
  localparam int LINE_B_L_PCT = 22;
  localparam int LINE_B_R_PCT = 84;

  localparam rgb_t LINE_A_COLOUR = '{red: 8'd56, green: 8'd126, blue: 8'd164};
  localparam rgb_t LINE_B_COLOUR = '{red: 8'd42, green: 8'd104, blue: 8'd146};

  // Gradient end colours: top row (t = 0) and bottom limit (t = 255)
  localparam rgb_t GRAD_TOP    = '{red: 8'd11, green: 8'd79, blue: 8'd130};
  localparam rgb_t GRAD_BOTTOM = '{red: 8'd6,  green: 8'd27, blue: 8'd49};

  // Reciprocal of 100 scaled by 2^26, rounded up; exact for products below 2^20
  localparam int RECIP_100   = 671089;
  localparam int RECIP_SHIFT = 26;

  // Exact floor(v / 255) for v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // floor(v * pct / 100) by one constant multiply
  function automatic logic [DIM_WIDTH-1:0] pct_of(input logic [DIM_WIDTH-1:0] v,
                                                  input int pct);
    logic [44:0] prod;
    prod = 45'(v) * 45'(pct * RECIP_100);
    return prod[RECIP_SHIFT+DIM_WIDTH-1:RECIP_SHIFT];
  endfunction

  // Undivided gradient channel: lo*(255-t) + hi*t
  function automatic logic [15:0] grad_sum(input logic [7:0] lo, input logic [7:0] hi,
                                           input logic [T_WIDTH-1:0] t);
    logic [15:0] s;
    s = 16'(lo) * 16'(8'd255 - t) + 16'(hi) * 16'(t);
    return s;
  endfunction

endpackage

[design/lapc_div.sv]
// Pipelined restoring divider: t = floor(y*255 / height), one quotient bit per stage.
// Depends on lapc_pkg; accepts a new operand every cycle.
module lapc_div (
  input  logic                            clk,
  input  logic [lapc_pkg::COORD_WIDTH-1:0] y,
  input  logic [lapc_pkg::DIM_WIDTH-1:0]   height,
  output logic [lapc_pkg::T_WIDTH-1:0]     t
);
  import lapc_pkg::*;

  localparam int DIVIDEND_W = COORD_WIDTH + 8;
  localparam int SHIFTED_W  = DIM_WIDTH + T_WIDTH - 1;
  localparam int DIV_W      = (DIVIDEND_W > SHIFTED_W) ? DIVIDEND_W : SHIFTED_W;

  logic [DIV_W-1:0]   dividend;
  logic [DIV_W-1:0]   rem [DIV_STAGES];
  logic [T_WIDTH-1:0] quo [DIV_STAGES];

  // y*255 as a shift and subtract
  assign dividend = (DIV_W'(y) << 8) - DIV_W'(y);

  // One compare-and-subtract per stage, most significant quotient bit first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [DIV_W-1:0]   rem_in;
    logic [T_WIDTH-1:0] quo_in;
    logic [DIV_W-1:0]   trial;
    logic               fits;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
    end

    assign trial = DIV_W'(height) << (DIV_STAGES - 1 - k);
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      rem[k] <= fits ? (rem_in - trial) : rem_in;
      quo[k] <= {quo_in[T_WIDTH-2:0], fits};
    end
  end

  assign t = quo[DIV_STAGES-1];

endmodule

[design/lapc_blend.sv]
// Source-over blend of one ARGB layer over an RGB colour, two register stages.
// Depends on lapc_pkg (rgb_t, div255); alpha 0 and 255 fall out of the same formula.
module lapc_blend (
  input  logic                           clk,
  input  lapc_pkg::rgb_t                 below,
  input  logic [lapc_pkg::ARGB_WIDTH-1:0] layer,
  output lapc_pkg::rgb_t                 blended
);
  import lapc_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [15:0] sum_red;
  logic [15:0] sum_green;
  logic [15:0] sum_blue;

  assign alpha     = layer[31:24];
  assign inv_alpha = 8'd255 - alpha;

  // Weight source and destination
  always_ff @(posedge clk) begin
    sum_red   <= 16'(layer[23:16]) * 16'(alpha) + 16'(below.red)   * 16'(inv_alpha);
    sum_green <= 16'(layer[15:8])  * 16'(alpha) + 16'(below.green) * 16'(inv_alpha);
    sum_blue  <= 16'(layer[7:0])   * 16'(alpha) + 16'(below.blue)  * 16'(inv_alpha);
  end

  // Truncate by 255
  always_ff @(posedge clk) begin
    blended.red   <= div255(sum_red);
    blended.green <= div255(sum_green);
    blended.blue  <= div255(sum_blue);
  end

endmodule

[design/layered_alpha_pixel_compositor_core.sv]
// Layered alpha pixel compositor: gradient background, two windows and a taskbar.
// Depends on lapc_pkg, lapc_div and lapc_blend.
//
// One pixel enters per clock: a transaction is taken whenever start is high, and busy
// is never raised. Each pixel on screen appears on result with done high for one cycle,
// in order; a pixel outside the screen gives no done. The path to result runs through
// the input register, the 8-stage gradient divider, two gradient stages, three
// two-stage layer blends and the output register. The receiver cannot hold results
// off, so result is simply valid for the single cycle marked by done. Register writes
// apply to pixels issued after the write, and some also reach pixels in the pipeline.
module layered_alpha_pixel_compositor_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  lapc_pkg::pixel_in_t                 command,
  output logic                                done,
  output lapc_pkg::pixel_out_t                result,
  input  logic                                cfg_write,
  input  logic [lapc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lapc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import lapc_pkg::*;

  // Stage positions along the item pipeline
  localparam int IDX_STAGE  = 1;
  localparam int SUM_STAGE  = IDX_STAGE + 1;
  localparam int FLAG_STAGE = SUM_STAGE + 1;
  localparam int T_STAGE    = DIV_STAGES;
  localparam int GRAD_STAGE = T_STAGE + 1;
  localparam int BG_STAGE   = GRAD_STAGE + 1;
  localparam int MID_STAGE  = BG_STAGE + BLEND_LAT;
  localparam int TOP_STAGE  = MID_STAGE + BLEND_LAT;
  localparam int LAST_STAGE = TOP_STAGE + BLEND_LAT;
  localparam int PROD_W     = (COORD_WIDTH + STRIDE_WIDTH > INDEX_WIDTH) ?
                              (COORD_WIDTH + STRIDE_WIDTH) : INDEX_WIDTH;
  localparam int CMP_W      = (COORD_WIDTH > STRIDE_WIDTH) ? COORD_WIDTH : STRIDE_WIDTH;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [ARGB_WIDTH-1:0]  layer_bottom;
    logic [ARGB_WIDTH-1:0]  layer_middle;
    logic [ARGB_WIDTH-1:0]  layer_top;
    logic                   on_line_a;
    logic                   on_line_b;
    logic [INDEX_WIDTH-1:0] index;
  } item_t;

  // Configuration registers
  logic [DIM_WIDTH-1:0]    screen_width;
  logic [DIM_WIDTH-1:0]    screen_height;
  logic [STRIDE_WIDTH-1:0] line_stride;
  logic                    pixel_order;
  logic                    top_window;

  // Line geometry derived from the screen size
  logic [DIM_WIDTH-1:0]    line_a_row;
  logic [STRIDE_WIDTH-1:0] line_b_row;
  logic [DIM_WIDTH-1:0]    line_a_left;
  logic [DIM_WIDTH-1:0]    line_a_right;
  logic [DIM_WIDTH-1:0]    line_b_left;
  logic [DIM_WIDTH-1:0]    line_b_right;

  logic              accept;
  logic              in_range;
  item_t             entry;
  item_t             side      [LAST_STAGE+1];
  item_t             side_next [LAST_STAGE+1];
  logic [LAST_STAGE:0] vld;
  logic [PROD_W-1:0] idx_prod;

  logic [T_WIDTH-1:0] grad_t;
  logic [15:0]        grad_red;
  logic [15:0]        grad_green;
  logic [15:0]        grad_blue;
  rgb_t               bg_rgb;
  rgb_t               mid_rgb;
  rgb_t               top_rgb;
  rgb_t               final_rgb;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      line_stride   <= STRIDE_RESET;
      pixel_order   <= 1'b0;
      top_window    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_WIDTH-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_WIDTH-1:0];
        REG_LINE_STRIDE:   line_stride   <= cfg_data[STRIDE_WIDTH-1:0];
        REG_PIXEL_ORDER:   pixel_order   <= cfg_data[0];
        REG_TOP_WINDOW:    top_window    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Recompute line geometry from the current screen size
  always_ff @(posedge clk) begin
    line_a_row   <= pct_of(screen_height, LINE_ROW_PCT);
    line_b_row   <= STRIDE_WIDTH'(pct_of(screen_height, LINE_ROW_PCT)) +
                    STRIDE_WIDTH'(LINE_GAP);
    line_a_left  <= pct_of(screen_width, LINE_A_L_PCT);
    line_a_right <= pct_of(screen_width, LINE_A_R_PCT);
    line_b_left  <= pct_of(screen_width, LINE_B_L_PCT);
    line_b_right <= pct_of(screen_width, LINE_B_R_PCT);
  end

  // Clip to the screen and order the windows bottom to top
  assign in_range = (CMP_W'(command.pixel_x) < CMP_W'(screen_width)) &&
                    (CMP_W'(command.pixel_y) < CMP_W'(screen_height));

  always_comb begin
    entry.x            = command.pixel_x;
    entry.y            = command.pixel_y;
    entry.layer_bottom = top_window ? command.window_one_pixel : command.window_two_pixel;
    entry.layer_middle = top_window ? command.window_two_pixel : command.window_one_pixel;
    entry.layer_top    = command.taskbar_pixel;
    entry.on_line_a    = 1'b0;
    entry.on_line_b    = 1'b0;
    entry.index        = '0;
  end

  assign idx_prod = PROD_W'(side[IDX_STAGE-1].y) * PROD_W'(line_stride);

  // Advance the item line; index and line hits fill in on the way
  always_comb begin
    side_next[0] = entry;
    for (int k = 1; k <= LAST_STAGE; k++) begin
      side_next[k] = side[k-1];
    end
    side_next[IDX_STAGE].index = idx_prod[INDEX_WIDTH-1:0];
    side_next[SUM_STAGE].index = side[SUM_STAGE-1].index +
                                 INDEX_WIDTH'(side[SUM_STAGE-1].x);
    side_next[FLAG_STAGE].on_line_a =
      (CMP_W'(side[FLAG_STAGE-1].y) == CMP_W'(line_a_row)) &&
      (CMP_W'(side[FLAG_STAGE-1].x) >  CMP_W'(line_a_left)) &&
      (CMP_W'(side[FLAG_STAGE-1].x) <  CMP_W'(line_a_right));
    side_next[FLAG_STAGE].on_line_b =
      (CMP_W'(side[FLAG_STAGE-1].y) == CMP_W'(line_b_row)) &&
      (CMP_W'(side[FLAG_STAGE-1].x) >  CMP_W'(line_b_left)) &&
      (CMP_W'(side[FLAG_STAGE-1].x) <  CMP_W'(line_b_right));
  end

  always_ff @(posedge clk) begin
    side <= side_next;
  end

  // Valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAST_STAGE-1:0], accept && in_range};
    end
  end

  // Gradient position t = y*255/height
  lapc_div u_div (
    .clk    (clk),
    .y      (side[0].y),
    .height (screen_height),
    .t      (grad_t)
  );

  // Weight the gradient end colours
  always_ff @(posedge clk) begin
    grad_red   <= grad_sum(GRAD_TOP.red,   GRAD_BOTTOM.red,   grad_t);
    grad_green <= grad_sum(GRAD_TOP.green, GRAD_BOTTOM.green, grad_t);
    grad_blue  <= grad_sum(GRAD_TOP.blue,  GRAD_BOTTOM.blue,  grad_t);
  end

  // Finish the background; the lower line wins over the upper one
  always_ff @(posedge clk) begin
    priority if (side[GRAD_STAGE].on_line_b) begin
      bg_rgb <= LINE_B_COLOUR;
    end else if (side[GRAD_STAGE].on_line_a) begin
      bg_rgb <= LINE_A_COLOUR;
    end else begin
      bg_rgb.red   <= div255(grad_red);
      bg_rgb.green <= div255(grad_green);
      bg_rgb.blue  <= div255(grad_blue);
    end
  end

  // Blend the lower window, the upper window, then the taskbar
  lapc_blend u_blend_bottom (
    .clk     (clk),
    .below   (bg_rgb),
    .layer   (side[BG_STAGE].layer_bottom),
    .blended (mid_rgb)
  );

  lapc_blend u_blend_middle (
    .clk     (clk),
    .below   (mid_rgb),
    .layer   (side[MID_STAGE].layer_middle),
    .blended (top_rgb)
  );

  lapc_blend u_blend_top (
    .clk     (clk),
    .below   (top_rgb),
    .layer   (side[TOP_STAGE].layer_top),
    .blended (final_rgb)
  );

  // Pack the pixel and present the transaction for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST_STAGE];
    end
  end

  always_ff @(posedge clk) begin
    result.pixel_index <= side[LAST_STAGE].index;
    if (pixel_order) begin
      result.pixel_word <= {final_rgb.red, final_rgb.green, final_rgb.blue};
    end else begin
      result.pixel_word <= {final_rgb.blue, final_rgb.green, final_rgb.red};
    end
  end

  // A result comes out only for an on-screen pixel taken a fixed latency earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && in_range, LAST_STAGE + 2))
    else $error("result without a matching on-screen transaction");

  // Every on-screen pixel comes out after the fixed latency
  a_source_gives_done: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range) |-> ##(LAST_STAGE + 2) done)
    else $error("on-screen transaction lost in the pipeline");

endmodule

[dv/pixel_compositor_checker.sv]
`timescale 1ns / 100ps
// Checker for the layered alpha pixel compositor: watches the pixel, result and
// register write ports, predicts each composited pixel and compares it field by field.
// Depends on lapc_pkg for the port types, register indexes and colour constants.
module pixel_compositor_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  lapc_pkg::pixel_in_t                  command,
  input  logic                                 done,
  input  lapc_pkg::pixel_out_t                 result,
  input  logic                                 cfg_write,
  input  logic [lapc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lapc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                                   mismatches,
  output int                                   pixels_due_count,
  output int                                   pixels_checked
);
  import lapc_pkg::*;

  // Shadow copy of the screen registers
  logic [DIM_WIDTH-1:0]    scr_width;
  logic [DIM_WIDTH-1:0]    scr_height;
  logic [STRIDE_WIDTH-1:0] scr_stride;
  logic                    order_bgr;
  logic                    window_two_on_top;

  // Composited pixels still to come out, oldest first
  pixel_out_t pixels_due[$];

  // Source-over on one channel, truncating division by 255
  function automatic logic [7:0] mix_channel(input logic [7:0] src, input logic [7:0] dst,
                                             input logic [7:0] alpha);
    int a;
    a = int'(alpha);
    if (a == 255) return src;
    return 8'((int'(src) * a + int'(dst) * (255 - a)) / 255);
  endfunction

  // Lay one ARGB layer over the colour below; alpha 0 leaves it untouched
  function automatic rgb_t blend_layer(input rgb_t below, input logic [ARGB_WIDTH-1:0] layer);
    rgb_t above;
    if (layer[31:24] == 8'd0) return below;
    above.red   = mix_channel(layer[23:16], below.red,   layer[31:24]);
    above.green = mix_channel(layer[15:8],  below.green, layer[31:24]);
    above.blue  = mix_channel(layer[7:0],   below.blue,  layer[31:24]);
    return above;
  endfunction

  function automatic logic [7:0] grad_channel(input logic [7:0] top_c,
                                              input logic [7:0] bottom_c, input int t);
    return 8'((int'(top_c) * (255 - t) + int'(bottom_c) * t) / 255);
  endfunction

  // Work out the framebuffer pixel for one transaction; 0 when off screen
  function automatic bit composite_pixel(input pixel_in_t px, output pixel_out_t px_out);
    int   x, y, w, h, t, row;
    rgb_t c;
    x = int'(px.pixel_x);
    y = int'(px.pixel_y);
    w = int'(scr_width);
    h = int'(scr_height);
    px_out = '0;
    if (x >= w || y >= h) return 1'b0;

    // Vertical gradient, then the two background lines
    t = y * 255 / h;
    c.red   = grad_channel(GRAD_TOP.red,   GRAD_BOTTOM.red,   t);
    c.green = grad_channel(GRAD_TOP.green, GRAD_BOTTOM.green, t);
    c.blue  = grad_channel(GRAD_TOP.blue,  GRAD_BOTTOM.blue,  t);
    row = h * LINE_ROW_PCT / 100;
    if (y == row && x > w * LINE_A_L_PCT / 100 && x < w * LINE_A_R_PCT / 100)
      c = LINE_A_COLOUR;
    if (y == row + LINE_GAP && x > w * LINE_B_L_PCT / 100 && x < w * LINE_B_R_PCT / 100)
      c = LINE_B_COLOUR;

    // Windows in focus order, taskbar always last
    if (window_two_on_top) begin
      c = blend_layer(c, px.window_one_pixel);
      c = blend_layer(c, px.window_two_pixel);
    end else begin
      c = blend_layer(c, px.window_two_pixel);
      c = blend_layer(c, px.window_one_pixel);
    end
    c = blend_layer(c, px.taskbar_pixel);

    px_out.pixel_word  = order_bgr ? {c.red, c.green, c.blue} : {c.blue, c.green, c.red};
    px_out.pixel_index = INDEX_WIDTH'(y * int'(scr_stride) + x);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    pixel_out_t oldest;
    pixel_out_t fresh;
    if (rst) begin
      scr_width         = WIDTH_RESET;
      scr_height        = HEIGHT_RESET;
      scr_stride        = STRIDE_RESET;
      order_bgr         = 1'b0;
      window_two_on_top = 1'b0;
      mismatches        = 0;
      pixels_checked    = 0;
      pixels_due.delete();
    end else begin
      // Compare each result transaction with the oldest prediction
      if (done) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected result: pixel_index %0d pixel_word %06h",
                 result.pixel_index, result.pixel_word);
          mismatches++;
        end else begin
          oldest = pixels_due.pop_front();
          if (result.pixel_index !== oldest.pixel_index) begin
            $error("pixel_index mismatch: expected %0d, actual %0d",
                   oldest.pixel_index, result.pixel_index);
            mismatches++;
          end
          if (result.pixel_word !== oldest.pixel_word) begin
            $error("pixel_word mismatch: expected %06h, actual %06h",
                   oldest.pixel_word, result.pixel_word);
            mismatches++;
          end
          pixels_checked++;
        end
      end

      // Predict accepted pixel transactions
      if (start && !busy && composite_pixel(command, fresh))
        pixels_due.push_back(fresh);

      // Track register writes; indexes past the list are dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_width         = cfg_data[DIM_WIDTH-1:0];
          REG_SCREEN_HEIGHT: scr_height        = cfg_data[DIM_WIDTH-1:0];
          REG_LINE_STRIDE:   scr_stride        = cfg_data[STRIDE_WIDTH-1:0];
          REG_PIXEL_ORDER:   order_bgr         = cfg_data[0];
          REG_TOP_WINDOW:    window_two_on_top = cfg_data[0];
          default: ;
        endcase
      end
    end
    pixels_due_count = pixels_due.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the layered alpha pixel compositor: clock, reset, pixel and
// register stimulus, and the verdict. Depends on lapc_pkg, the compositor core and
// pixel_compositor_checker.
module tb;
  import lapc_pkg::*;

  localparam int COORD_SPAN   = 1 << COORD_WIDTH;
  // Pipeline depth plus margin, for pixels that leave no result behind
  localparam int DRAIN_CYCLES = 24;
  localparam int NUM_MODES    = 7;
  // A register index beyond the list, written to check that it is dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_SPARE = 3'd5;

  typedef struct packed {
    logic [CFG_DATA_WIDTH-1:0] width;
    logic [CFG_DATA_WIDTH-1:0] height;
    logic [CFG_DATA_WIDTH-1:0] stride;
    logic                      bgr;
    logic                      swap;
    logic [15:0]               items;
  } screen_mode_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  pixel_in_t                  command;
  logic                       done;
  pixel_out_t                 result;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  int           mismatches;
  int           pixels_due_count;
  int           pixels_checked;
  int           pixels_sent;
  int           cur_w;
  int           cur_h;
  bit           burst;
  screen_mode_t modes [NUM_MODES];

  layered_alpha_pixel_compositor_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_compositor_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .done             (done),
    .result           (result),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pixels_due_count (pixels_due_count),
    .pixels_checked   (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hand one pixel transaction over after a random gap, or none in a burst; returns on a falling edge
  task automatic send_pixel(input pixel_in_t px);
    int gap;
    gap = burst ? 0 : $urandom_range(8, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command <= px;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_xy(input int x, input int y, input logic [31:0] w1,
                         input logic [31:0] w2, input logic [31:0] bar);
    pixel_in_t px;
    px.pixel_x          = COORD_WIDTH'(x);
    px.pixel_y          = COORD_WIDTH'(y);
    px.window_one_pixel = w1;
    px.window_two_pixel = w2;
    px.taskbar_pixel    = bar;
    send_pixel(px);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Drain the pipeline, then load a new screen mode
  task automatic enter_mode(input screen_mode_t m);
    start <= 1'b0;
    while (pixels_due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_SCREEN_WIDTH, m.width);
    write_reg(REG_SCREEN_HEIGHT, m.height);
    write_reg(REG_LINE_STRIDE, m.stride);
    write_reg(REG_PIXEL_ORDER, {13'd0, m.bgr});
    write_reg(REG_TOP_WINDOW, {13'd0, m.swap});
    write_reg(CFG_INDEX_SPARE, 14'h2aaa);
    cfg_write <= 1'b0;
    // Writes reach pixels issued after them
    repeat (2) @(negedge clk);
    cur_w = int'(m.width[DIM_WIDTH-1:0]);
    cur_h = int'(m.height[DIM_WIDTH-1:0]);
  endtask

  // Uncovered, opaque, transparent-with-colour, or fully random layer value
  function automatic logic [31:0] random_layer();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel < 3) return 32'd0;
    if (sel < 5) return {8'hff, 24'($urandom)};
    if (sel < 6) return {8'h00, 24'($urandom)};
    return $urandom;
  endfunction

  // Mostly on-screen pixels, some on the background lines and their ends, some anywhere
  function automatic pixel_in_t random_pixel(input int w, input int h);
    pixel_in_t px;
    int        sel, row, pct, x, y;
    sel = $urandom_range(9, 0);
    x = $urandom_range(COORD_SPAN - 1, 0);
    y = $urandom_range(COORD_SPAN - 1, 0);
    if (w > 0 && h > 0 && sel < 7) begin
      x = $urandom_range((w > COORD_SPAN ? COORD_SPAN : w) - 1, 0);
      y = $urandom_range((h > COORD_SPAN ? COORD_SPAN : h) - 1, 0);
    end else if (w > 0 && h > 0 && sel < 9) begin
      row = h * LINE_ROW_PCT / 100 + ($urandom_range(1, 0) ? LINE_GAP : 0);
      if (row < COORD_SPAN) y = row;
      case ($urandom_range(3, 0))
        0:       pct = LINE_A_L_PCT;
        1:       pct = LINE_A_R_PCT;
        2:       pct = LINE_B_L_PCT;
        default: pct = LINE_B_R_PCT;
      endcase
      if ($urandom_range(1, 0))
        x = w * pct / 100 + $urandom_range(2, 0) - 1;
      else
        x = $urandom_range((w > COORD_SPAN ? COORD_SPAN : w) - 1, 0);
    end
    px.pixel_x          = COORD_WIDTH'(x);
    px.pixel_y          = COORD_WIDTH'(y);
    px.window_one_pixel = random_layer();
    px.window_two_pixel = random_layer();
    px.taskbar_pixel    = random_layer();
    return px;
  endfunction

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    command     = '0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    burst       = 1'b0;
    pixels_sent = 0;
    cur_w       = int'(WIDTH_RESET);
    cur_h       = int'(HEIGHT_RESET);

    // Reset values first, then small, maximum, overwide, zero and common modes
    modes[0] = '{14'd1024,  14'd768,   14'd1024,  1'b0, 1'b0, 16'd230};
    modes[1] = '{14'd800,   14'd600,   14'd800,   1'b0, 1'b0, 16'd250};
    modes[2] = '{14'd4096,  14'd4096,  14'd8192,  1'b1, 1'b1, 16'd250};
    modes[3] = '{14'h3fff,  14'h3fff,  14'h3fff,  1'b0, 1'b1, 16'd250};
    modes[4] = '{14'd0,     14'd0,     14'd1,     1'b1, 1'b0, 16'd20};
    modes[5] = '{14'd1920,  14'd1080,  14'd2048,  1'b1, 1'b0, 16'd250};
    modes[6] = '{14'd1024,  14'd768,   14'd1024,  1'b0, 1'b1, 16'd250};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: screen corners and edges, background line ends, alpha extremes
    send_xy(0,    0,    32'h0, 32'h0, 32'h0);
    send_xy(1023, 767,  32'h0, 32'h0, 32'h0);
    send_xy(1024, 0,    32'h0, 32'h0, 32'h0);
    send_xy(0,    768,  32'h0, 32'h0, 32'h0);
    send_xy(4095, 4095, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_xy(185,  399,  32'h0, 32'h0, 32'h0);
    send_xy(184,  399,  32'h0, 32'h0, 32'h0);
    send_xy(920,  399,  32'h0, 32'h0, 32'h0);
    send_xy(921,  399,  32'h0, 32'h0, 32'h0);
    send_xy(226,  437,  32'h0, 32'h0, 32'h0);
    send_xy(225,  437,  32'h0, 32'h0, 32'h0);
    send_xy(859,  437,  32'h0, 32'h0, 32'h0);
    send_xy(860,  437,  32'h0, 32'h0, 32'h0);
    send_xy(300,  200,  32'hffa0b0c0, 32'hff102030, 32'h0);
    send_xy(301,  200,  32'h80102030, 32'h80f0e0d0, 32'h0);
    send_xy(302,  200,  32'h00ffffff, 32'h00ffffff, 32'h00ffffff);
    send_xy(303,  200,  32'hffa0b0c0, 32'h80102030, 32'hff123456);
    send_xy(304,  200,  32'hfe000000, 32'h0, 32'h01ffffff);
    send_xy(500,  399,  32'h0, 32'h0, 32'h80808080);
    send_xy(1023, 0,    32'h7f00ff00, 32'hffffffff, 32'h0);
    send_xy(0,    767,  32'h01ffffff, 32'hfe000000, 32'hffffffff);

    // Random pixels in each screen mode, with stretches of back-to-back transactions
    for (int m = 0; m < NUM_MODES; m++) begin
      if (m > 0) enter_mode(modes[m]);
      for (int i = 0; i < int'(modes[m].items); i++) begin
        if (i % 32 == 0) burst = ($urandom_range(3, 0) == 0);
        send_pixel(random_pixel(cur_w, cur_h));
      end
    end

    start <= 1'b0;
    while (pixels_due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d pixel transactions over %0d screen modes, %0d composited pixels checked.",
             pixels_sent, NUM_MODES, pixels_checked);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
